FILE: rtl/tea_pkg.sv
// Package: shared types and constants for triangle edge adjacency.
`default_nettype none
package tea_pkg;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned IndexW   = 10;
  localparam int unsigned EdgeW    = 2;
  localparam int unsigned ResultCap = 4;

  localparam logic [EdgeW-1:0] EdgeNone = 2'd3;

  typedef enum logic {
    KIND_CLEAR = 1'b0,
    KIND_LOAD  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
  } vertex_t;

  typedef struct packed {
    vertex_t a;
    vertex_t b;
    vertex_t c;
  } tri_t;

  typedef struct packed {
    logic                  kind;
    logic [CoordW-1:0]     a_x;
    logic [CoordW-1:0]     a_y;
    logic [CoordW-1:0]     a_z;
    logic [CoordW-1:0]     b_x;
    logic [CoordW-1:0]     b_y;
    logic [CoordW-1:0]     b_z;
    logic [CoordW-1:0]     c_x;
    logic [CoordW-1:0]     c_y;
    logic [CoordW-1:0]     c_z;
  } in_item_t;

  typedef struct packed {
    logic              matched;
    logic [IndexW-1:0] earlier_index;
    logic [IndexW-1:0] new_index;
    logic [EdgeW-1:0]  earlier_edge;
    logic [EdgeW-1:0]  new_edge;
    logic              overflow;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch new triangle, reset scan
    logic clear;     // empty the store
    logic rd_en;     // issue read at scan pointer
    logic cmp_en;    // compare read data, advance
    logic commit;    // write new triangle, bump count
    logic pop;       // next hit
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic scan_done;
    logic last_hit;
  } dp_stat_t;

  function automatic logic f32_eq(logic [CoordW-1:0] a, logic [CoordW-1:0] b);
    logic a_nan, b_nan, a_z, b_z;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    a_z = (a[30:0] == '0);
    b_z = (b[30:0] == '0);
    return !a_nan && !b_nan && ((a == b) || (a_z && b_z));
  endfunction

  function automatic logic v_eq(vertex_t a, vertex_t b);
    return f32_eq(a.x, b.x) && f32_eq(a.y, b.y) && f32_eq(a.z, b.z);
  endfunction

  function automatic logic v_in(tri_t t, vertex_t v);
    return v_eq(t.a, v) || v_eq(t.b, v) || v_eq(t.c, v);
  endfunction

  function automatic logic [EdgeW-1:0] shared_edge(tri_t a, tri_t b);
    logic ia, ib, ic;
    logic [EdgeW-1:0] r;
    ia = v_in(b, a.a);
    ib = v_in(b, a.b);
    ic = v_in(b, a.c);
    if (ia && ib) r = 2'd0;
    else if (ib && ic) r = 2'd1;
    else if (ic && ia) r = 2'd2;
    else r = EdgeNone;
    return r;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/tea_if.sv
// Interfaces: valid/ready channels for input and result items.
`default_nettype none
interface tea_in_if;
  logic valid;
  logic ready;
  tea_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tea_out_if;
  logic valid;
  logic ready;
  tea_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/tea_ctrl.sv
// Controller: sequences capture, store scan, commit and result emission.
`default_nettype none
module tea_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_kind_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire tea_pkg::dp_stat_t stat_i,
  output tea_pkg::ctl_cmd_t  cmd_o
);
  import tea_pkg::*;

  state_e state_q, state_d;
  logic acc, fire_out;

  assign acc = in_valid_i && in_ready_o;
  assign fire_out = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc && in_kind_i == KIND_LOAD) begin
          state_d = stat_i.full ? ST_EMIT : ST_READ;
        end
      end
      ST_READ: state_d = stat_i.scan_done ? ST_DRAIN : ST_SCAN;
      ST_SCAN: state_d = stat_i.scan_done ? ST_DRAIN : ST_SCAN;
      ST_DRAIN: state_d = ST_EMIT;
      ST_EMIT: begin
        if (fire_out && stat_i.last_hit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.capture = acc && in_kind_i == KIND_LOAD;
        cmd_o.clear = acc && in_kind_i == KIND_CLEAR;
      end
      ST_READ: cmd_o.rd_en = 1'b1;
      ST_SCAN: begin
        cmd_o.cmp_en = 1'b1;
        cmd_o.rd_en = 1'b1;
      end
      ST_DRAIN: cmd_o.commit = 1'b1;
      ST_EMIT: begin
        out_valid_o = 1'b1;
        cmd_o.pop = fire_out;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("in and out active together");
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
  a_commit_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> !cmd_o.commit) else $error("double commit");
`endif
endmodule
`default_nettype wire

FILE: rtl/tea_dp.sv
// Datapath: triangle store, edge compare, hit list and result fields.
`default_nettype none
module tea_dp #(
  parameter int unsigned MaxTriangles = 1024,
  parameter int unsigned MaxMatches   = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tea_pkg::ctl_cmd_t cmd_i,
  input  wire tea_pkg::tri_t     tri_i,
  output tea_pkg::dp_stat_t      stat_o,
  output tea_pkg::out_item_t     out_o
);
  import tea_pkg::*;

  localparam int unsigned CntW = $clog2(MaxTriangles + 1);
  localparam int unsigned AdrW = $clog2(MaxTriangles);
  localparam int unsigned Limit = (MaxMatches < ResultCap) ? MaxMatches : ResultCap;
  localparam int unsigned HitW = $clog2(ResultCap + 1);
  localparam int unsigned SelW = $clog2(ResultCap);

  tri_t mem [MaxTriangles];
  tri_t rd_q;
  tri_t new_q;
  logic [CntW-1:0] count_q, rp_q, cp_q;
  logic full_q;
  logic ovf_q;
  logic [HitW-1:0] n_q, ptr_q;
  logic [IndexW-1:0] he_q [ResultCap];
  logic [EdgeW-1:0] hee_q [ResultCap];
  logic [EdgeW-1:0] hne_q [ResultCap];
  logic [EdgeW-1:0] ne, ee;
  logic [SelW-1:0] sel;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) rd_q <= mem[rp_q[AdrW-1:0]];
    if (cmd_i.commit) mem[count_q[AdrW-1:0]] <= new_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) new_q <= tri_i;
  end

  assign ne = shared_edge(new_q, rd_q);
  assign ee = shared_edge(rd_q, new_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp_en && ne != EdgeNone && n_q < HitW'(Limit)) begin
      he_q[n_q[SelW-1:0]]  <= IndexW'(cp_q);
      hee_q[n_q[SelW-1:0]] <= ee;
      hne_q[n_q[SelW-1:0]] <= ne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rp_q <= '0;
      cp_q <= '0;
      n_q <= '0;
      ptr_q <= '0;
      ovf_q <= 1'b0;
      full_q <= 1'b0;
    end else begin
      if (cmd_i.clear) count_q <= '0;
      if (cmd_i.capture) begin
        rp_q <= '0;
        cp_q <= '0;
        n_q <= '0;
        ptr_q <= '0;
        full_q <= (count_q >= CntW'(MaxTriangles));
        ovf_q <= (count_q >= CntW'(MaxTriangles));
      end
      if (cmd_i.rd_en) rp_q <= rp_q + 1'b1;
      if (cmd_i.cmp_en) begin
        cp_q <= cp_q + 1'b1;
        if (ne != EdgeNone) begin
          if (n_q < HitW'(Limit)) n_q <= n_q + 1'b1;
          else ovf_q <= 1'b1;
        end
      end
      if (cmd_i.commit) count_q <= count_q + 1'b1;
      if (cmd_i.pop) ptr_q <= ptr_q + 1'b1;
    end
  end

  // the cycle reading entry cp feeds compare next cycle
  assign stat_o.full = (count_q >= CntW'(MaxTriangles));
  assign stat_o.scan_done = (rp_q >= count_q);
  assign stat_o.last_hit = (n_q == '0) || (ptr_q + 1'b1 >= n_q);

  assign sel = ptr_q[SelW-1:0];

  always_comb begin
    out_o = '0;
    out_o.overflow = ovf_q;
    out_o.last = stat_o.last_hit;
    if (!full_q) out_o.new_index = IndexW'(count_q - 1'b1);
    if (n_q != '0) begin
      out_o.matched = 1'b1;
      out_o.earlier_index = he_q[sel];
      out_o.earlier_edge = hee_q[sel];
      out_o.new_edge = hne_q[sel];
    end
  end

`ifndef SYNTHESIS
  a_hits_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= HitW'(Limit)) else $error("hit count over limit");
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxTriangles)) else $error("count over capacity");
  a_full_no_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> count_q < CntW'(MaxTriangles)) else $error("commit into full store");
`endif
endmodule
`default_nettype wire

FILE: rtl/triangle_edge_adjacency_top.sv
// Top level: triangle edge adjacency finder.
//  channel | dir | payload
//  in_if   | in  | kind, a_x..c_z
//  out_if  | out | matched, earlier_index, new_index, earlier_edge, new_edge, overflow, last
// A taken load runs READ and SCAN (one store read a cycle), then DRAIN stores the new triangle;
// results then leave one per cycle while out_if.ready is high, up to four.
// A load into a full store skips the scan. Reset empties the store at once.
// No new item is taken until the last result of the current one has left.
`default_nettype none
module triangle_edge_adjacency_top #(
  parameter int unsigned MaxTriangles = 1024,
  parameter int unsigned MaxMatches   = 4
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  tea_in_if.sink   in_if,
  tea_out_if.source out_if
);
  import tea_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;
  tri_t tri_in;

  assign tri_in.a = '{x: in_if.data.a_x, y: in_if.data.a_y, z: in_if.data.a_z};
  assign tri_in.b = '{x: in_if.data.b_x, y: in_if.data.b_y, z: in_if.data.b_z};
  assign tri_in.c = '{x: in_if.data.c_x, y: in_if.data.c_y, z: in_if.data.c_z};

  tea_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_kind_i  (in_if.data.kind),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tea_dp #(.MaxTriangles(MaxTriangles), .MaxMatches(MaxMatches)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i (cmd),
    .tri_i (tri_in),
    .stat_o(stat),
    .out_o (out_if.data)
  );
endmodule
`default_nettype wire

FILE: tb/sv/tb_triangle_edge_adjacency_top.sv
// Testbench: random and directed triangle loads checked against an adjacency scoreboard.
`default_nettype none
module tb_triangle_edge_adjacency_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tea_pkg::*;

  localparam int unsigned StoreDepth = 1024;
  localparam int unsigned MatchLimit = 4;
  localparam longint unsigned CycleLimit = 4000000;

  class adjacency_scoreboard;
    tri_t tris[StoreDepth];
    int unsigned tri_count;
    out_item_t pending[$];
    int unsigned errors;

    function automatic bit coord_eq(logic [31:0] a, logic [31:0] b);
      bit a_nan, b_nan;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 0);
      if (a_nan || b_nan) return 0;
      return (a == b) || (a[30:0] == 0 && b[30:0] == 0);
    endfunction

    function automatic bit vtx_eq(vertex_t a, vertex_t b);
      return coord_eq(a.x, b.x) && coord_eq(a.y, b.y) && coord_eq(a.z, b.z);
    endfunction

    function automatic bit vtx_in_tri(tri_t t, vertex_t v);
      return vtx_eq(t.a, v) || vtx_eq(t.b, v) || vtx_eq(t.c, v);
    endfunction

    // first edge of t whose endpoints both lie in o
    function automatic logic [1:0] common_edge(tri_t t, tri_t o);
      vertex_t v[3];
      v[0] = t.a; v[1] = t.b; v[2] = t.c;
      for (int k = 0; k < 3; k++)
        if (vtx_in_tri(o, v[k]) && vtx_in_tri(o, v[(k + 1) % 3])) return 2'(k);
      return EdgeNone;
    endfunction

    function void note_input(in_item_t it);
      tri_t nt;
      out_item_t r, hits[$];
      logic [1:0] ne;
      bit ovf;
      if (it.kind != KIND_LOAD) begin
        tri_count = 0;
        return;
      end
      nt = {it.a_x, it.a_y, it.a_z, it.b_x, it.b_y, it.b_z, it.c_x, it.c_y, it.c_z};
      r = '0;
      if (tri_count >= StoreDepth) begin
        r.overflow = 1;
        r.last = 1;
        pending = {pending, r};
        return;
      end
      ovf = 0;
      for (int e = 0; e < tri_count; e++) begin
        ne = common_edge(nt, tris[e]);
        if (ne != EdgeNone) begin
          if (hits.size() < MatchLimit) begin
            r = '0;
            r.matched = 1;
            r.earlier_index = IndexW'(e);
            r.new_index = IndexW'(tri_count);
            r.new_edge = ne;
            r.earlier_edge = common_edge(tris[e], nt);
            hits = {hits, r};
          end else begin
            ovf = 1;
          end
        end
      end
      if (hits.size() == 0) begin
        r = '0;
        r.new_index = IndexW'(tri_count);
        r.last = 1;
        hits = {hits, r};
      end
      foreach (hits[i]) begin
        hits[i].overflow = ovf;
        hits[i].last = (i == hits.size() - 1);
        pending = {pending, hits[i]};
      end
      tris[tri_count] = nt;
      tri_count++;
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.matched !== exp.matched)
        report_field("matched", exp.matched, got.matched);
      if (got.earlier_index !== exp.earlier_index)
        report_field("earlier_index", exp.earlier_index, got.earlier_index);
      if (got.new_index !== exp.new_index)
        report_field("new_index", exp.new_index, got.new_index);
      if (got.earlier_edge !== exp.earlier_edge)
        report_field("earlier_edge", exp.earlier_edge, got.earlier_edge);
      if (got.new_edge !== exp.new_edge)
        report_field("new_edge", exp.new_edge, got.new_edge);
      if (got.overflow !== exp.overflow)
        report_field("overflow", exp.overflow, got.overflow);
      if (got.last !== exp.last)
        report_field("last", exp.last, got.last);
    endfunction

    function void report_field(string name, logic [15:0] exp, logic [15:0] got);
      $display("%0t: %s expected %0d got %0d", $time, name, exp, got);
      errors++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  tea_in_if in_if ();
  tea_out_if out_if ();

  triangle_edge_adjacency_top uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  adjacency_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  longint unsigned cycles;
  vertex_t pool[6];

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk_i)
    out_if.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i)
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.data);

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid = 0;
      @(negedge clk_i);
    end
    in_if.valid = 1;
    in_if.data = it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_input(it);
    @(negedge clk_i);
    in_if.valid = 0;
  endtask

  task automatic send_tri(vertex_t a, vertex_t b, vertex_t c);
    in_item_t it;
    it.kind = KIND_LOAD;
    {it.a_x, it.a_y, it.a_z} = a;
    {it.b_x, it.b_y, it.b_z} = b;
    {it.c_x, it.c_y, it.c_z} = c;
    send_item(it);
  endtask

  task automatic send_clear();
    in_item_t it;
    {it.a_x, it.a_y, it.a_z, it.b_x, it.b_y, it.b_z, it.c_x, it.c_y, it.c_z} =
      {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
       $urandom, $urandom};
    it.kind = KIND_CLEAR;
    send_item(it);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h3F80_0000;
      3: return 32'h7FC0_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    return {$urandom, $urandom, $urandom};
  endfunction

  task automatic refresh_pool();
    foreach (pool[i]) pool[i] = {pick_coord(), pick_coord(), pick_coord()};
  endtask

  task automatic run_random(int unsigned n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 7) begin
        send_clear();
        refresh_pool();
      end else if ($urandom_range(99) < 10) begin
        send_tri(rand_vertex(), rand_vertex(), rand_vertex());
      end else begin
        send_tri(pool[$urandom_range(5)], pool[$urandom_range(5)], pool[$urandom_range(5)]);
      end
    end
  endtask

  initial begin
    vertex_t va, vb, vc, vd, vz, vnz, vnan, vmax;
    sb = new();
    cycles = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    in_if.valid = 0;
    in_if.data = '0;
    out_if.ready = 0;
    rst_ni = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    va = {32'h3F80_0000, 32'h0000_0000, 32'h4000_0000};
    vb = {32'h4040_0000, 32'h3F80_0000, 32'h0000_0000};
    vc = {32'hBF80_0000, 32'h4080_0000, 32'h3F80_0000};
    vd = {32'h4100_0000, 32'h4120_0000, 32'hC000_0000};
    vz = {32'h0000_0000, 32'h0000_0000, 32'h0000_0000};
    vnz = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    vnan = {32'hFFFF_FFFF, 32'h7FC0_0000, 32'h0000_0000};
    vmax = {32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F80_0000};

    // directed: basic sharing, zero signs, NaN, degenerate, too many matches
    send_clear();
    send_tri(va, vb, vc);
    send_tri(vb, va, vd);
    send_tri(vc, vd, vb);
    send_tri(vz, va, vb);
    send_tri(vnz, vb, va);
    send_tri(vnan, va, vmax);
    send_tri(vnan, vmax, va);
    send_tri(va, va, vmax);
    send_tri(vd, vd, vd);
    send_clear();
    send_tri(va, vb, vc);
    send_tri(vnz, vnz, vb);
    send_tri(vz, vz, vz);
    send_tri(vmax, vb, vc);
    send_clear();
    for (int i = 0; i < 6; i++) send_tri(va, vb, rand_vertex());
    send_tri(vb, vd, va);
    send_clear();

    send_tri(va, vb, vc);
    send_tri(vmax, vnan, vz);
    send_clear();

    refresh_pool();
    run_random(50);
    send_idle_pct = 65;
    stall_pct = 0;
    run_random(50);
    send_idle_pct = 0;
    stall_pct = 65;
    run_random(50);
    send_idle_pct = 20;
    stall_pct = 20;
    run_random(50);

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
